// ===== rtl/core/mts_pkg.sv =====
package mts_pkg;

    // built sizes
    localparam int MAX_PROCESSORS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF    = 16;

    // scheduling strategies
    localparam logic [2:0] STRAT_FCFS      = 3'd0;
    localparam logic [2:0] STRAT_SJF       = 3'd1;
    localparam logic [2:0] STRAT_SRTF      = 3'd2;
    localparam logic [2:0] STRAT_RR        = 3'd3;
    localparam logic [2:0] STRAT_PRIO      = 3'd4;
    localparam logic [2:0] STRAT_PRIO_SRTF = 3'd5;
    localparam logic [2:0] STRAT_PRIO_NP   = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_STRATEGY = 2'd0;
    localparam logic [1:0] CFG_PROCS    = 2'd1;
    localparam logic [1:0] CFG_QUANTUM  = 2'd2;

    // input mode codes
    localparam logic MODE_ARRIVAL = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    localparam logic [15:0] IDLE_TASK = 16'hFFFF;

    typedef struct packed {
        logic [14:0] id;
        logic [7:0]  prio;
        logic [15:0] rem;
        logic [15:0] qrem;
    } t_task;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT_R,
        CELL_SHIFT_L,
        CELL_SORT
    } t_cell_op;

    typedef struct packed {
        t_cell_op   op;
        logic       phase;
        logic [2:0] strategy;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREEMPT,
        S_SORT,
        S_HEAD,
        S_FILL,
        S_EMIT,
        S_DEC
    } t_state;

    // strict ordering by strategy key, ties keep order
    function automatic logic key_less(input logic [2:0] strat, input t_task a, input t_task b);
        logic res;
        res = 1'b0;
        case (strat)
            STRAT_SJF, STRAT_SRTF: res = (a.rem < b.rem);
            STRAT_PRIO, STRAT_PRIO_NP: res = (a.prio < b.prio);
            STRAT_PRIO_SRTF: begin
                if (a.prio != b.prio)
                    res = (a.prio < b.prio);
                else
                    res = (a.rem < b.rem);
            end
            default: res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/core/multiprocessor_task_scheduler_unit.sv =====
// sequencing: an arrival is loaded into the queue as it is accepted; a tick walks the
// states preempt, sort, head, fill, emit and count-down, visiting one processor slot per
// step and running one odd-even exchange round per step across the queue cells
// throughput: one transaction at a time; input ready only while idle
// reset: synchronous active low, clears queue count, busy flags, time and overflow
module multiprocessor_task_scheduler_unit
    import mts_pkg::*;
#(
    parameter int MAX_PROCESSORS = MAX_PROCESSORS_DEF,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic [14:0]        i_task_id,
    input  logic [7:0]         i_task_priority,
    input  logic [15:0]        i_run_time,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_tick_time,
    output logic [2:0]         o_processor_index,
    output logic signed [15:0] o_assigned_task,
    output logic               o_queue_overflow,
    output logic               o_last_result
);

    localparam int CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_MAX = (MAX_PROCESSORS > QUEUE_DEPTH) ? MAX_PROCESSORS : QUEUE_DEPTH;
    localparam int SW      = $clog2(CNT_MAX + 1);
    localparam int PIW     = (MAX_PROCESSORS > 1) ? $clog2(MAX_PROCESSORS) : 1;

    // configuration registers
    logic [2:0]  r_strategy;
    logic [3:0]  r_procs;
    logic [15:0] r_quantum;

    t_state r_state, n_state;
    logic [SW-1:0] r_step;
    logic [CW-1:0] r_count;
    logic [31:0]   r_time;
    logic          r_ovf;

    logic  r_busy [MAX_PROCESSORS];
    t_task r_slot [MAX_PROCESSORS];

    logic        r_out_valid;
    logic [31:0] r_out_time;
    logic [2:0]  r_out_proc;
    logic [15:0] r_out_task;
    logic        r_out_ovf;
    logic        r_out_last;

    t_cell_ctl     w_ctl;
    t_task         w_din;
    t_task         w_cell_q [QUEUE_DEPTH];
    logic [PIW-1:0] w_sidx;
    t_task         w_stask;
    logic          w_sbusy;
    logic [SW-1:0] w_p;
    logic [SW:0]   w_held;
    logic          w_preempt;
    logic          w_acc;
    logic          w_arr_push, w_arr_drop;
    logic          w_pre_push, w_pre_free;
    logic          w_head_push, w_head_free;
    logic          w_fill, w_emit_load, w_out_free;
    logic          w_last_step;

    // queue cell row
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        mts_queue_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_count (r_count),
            .i_din   (w_din),
            .i_left  (w_cell_q[(g > 0) ? g - 1 : g]),
            .i_right (w_cell_q[(g < QUEUE_DEPTH - 1) ? g + 1 : g]),
            .o_task  (w_cell_q[g])
        );
    end

    // effective processor count
    always_comb begin
        if (r_procs == 4'd0)
            w_p = SW'(1);
        else if (int'(r_procs) > MAX_PROCESSORS)
            w_p = SW'(MAX_PROCESSORS);
        else
            w_p = SW'(r_procs);
    end

    // tasks held in queue and on processors
    always_comb begin
        w_held = (SW+1)'(r_count);
        for (int i = 0; i < MAX_PROCESSORS; i++)
            w_held = w_held + (SW+1)'(r_busy[i]);
    end

    assign w_preempt = (r_strategy >= STRAT_SRTF) && (r_strategy <= STRAT_PRIO_SRTF);
    assign w_acc     = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // slot visited this cycle
    assign w_sidx  = (r_state == S_HEAD) ? (PIW'(MAX_PROCESSORS - 1) - PIW'(r_step))
                                          : PIW'(r_step);
    assign w_stask = r_slot[w_sidx];
    assign w_sbusy = r_busy[w_sidx];

    // step end of the current phase
    always_comb begin
        w_last_step = 1'b0;
        unique case (r_state)
            S_SORT:  w_last_step = (r_step == SW'(QUEUE_DEPTH - 1));
            S_EMIT:  w_last_step = (r_step == w_p - SW'(1));
            default: w_last_step = (r_step == SW'(MAX_PROCESSORS - 1));
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (w_acc && i_mode == MODE_TICK) n_state = S_PREEMPT;
            S_PREEMPT: if (w_last_step) n_state = S_SORT;
            S_SORT:    if (w_last_step) n_state = S_HEAD;
            S_HEAD:    if (w_last_step) n_state = S_FILL;
            S_FILL:    if (w_last_step) n_state = S_EMIT;
            S_EMIT:    if (w_out_free && w_last_step) n_state = S_DEC;
            S_DEC:     n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // control outputs and cell commands
    always_comb begin
        o_in_ready   = 1'b0;
        w_arr_push   = 1'b0;
        w_arr_drop   = 1'b0;
        w_pre_push   = 1'b0;
        w_pre_free   = 1'b0;
        w_head_push  = 1'b0;
        w_head_free  = 1'b0;
        w_fill       = 1'b0;
        w_emit_load  = 1'b0;
        w_ctl.op       = CELL_HOLD;
        w_ctl.phase    = r_step[0];
        w_ctl.strategy = r_strategy;
        w_din          = w_stask;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_mode == MODE_ARRIVAL) begin
                    if (w_held >= (SW+1)'(QUEUE_DEPTH)) begin
                        w_arr_drop = 1'b1;
                    end else begin
                        w_arr_push = 1'b1;
                        w_ctl.op   = CELL_LOAD;
                        w_din      = '{id: i_task_id, prio: i_task_priority,
                                       rem: i_run_time, qrem: r_quantum};
                    end
                end
            end
            S_PREEMPT: begin
                if (w_preempt && w_sbusy) begin
                    if (w_stask.rem != 16'd0 && w_stask.qrem == 16'd0) begin
                        w_pre_push = 1'b1;
                        w_ctl.op   = CELL_LOAD;
                        w_din.qrem = r_quantum;
                    end else if (w_stask.rem == 16'd0) begin
                        w_pre_free = 1'b1;
                    end
                end
            end
            S_SORT: w_ctl.op = CELL_SORT;
            S_HEAD: begin
                if (w_sbusy) begin
                    w_head_free = 1'b1;
                    if (w_stask.rem != 16'd0) begin
                        w_head_push = 1'b1;
                        w_ctl.op    = CELL_SHIFT_R;
                    end
                end
            end
            S_FILL: begin
                if (r_step < w_p && r_count != CW'(0)) begin
                    w_fill   = 1'b1;
                    w_ctl.op = CELL_SHIFT_L;
                end
            end
            S_EMIT:  w_emit_load = w_out_free;
            S_DEC:   w_ctl.op = CELL_HOLD;
            default: w_ctl.op = CELL_HOLD;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strategy <= STRAT_FCFS;
            r_procs    <= 4'd1;
            r_quantum  <= 16'd1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_STRATEGY: r_strategy <= i_cfg_wdata[2:0];
                CFG_PROCS:    r_procs    <= i_cfg_wdata[3:0];
                CFG_QUANTUM:  r_quantum  <= i_cfg_wdata;
                default:      r_strategy <= r_strategy;
            endcase
        end
    end

    // sequencer, counters and processor slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_count <= '0;
            r_time  <= '0;
            r_ovf   <= 1'b0;
            for (int i = 0; i < MAX_PROCESSORS; i++)
                r_busy[i] <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state)
                r_step <= '0;
            else if (r_state != S_EMIT || w_emit_load)
                r_step <= r_step + SW'(1);

            if (w_arr_drop)
                r_ovf <= 1'b1;

            if (w_arr_push || w_pre_push || w_head_push)
                r_count <= r_count + CW'(1);
            else if (w_fill)
                r_count <= r_count - CW'(1);

            if (w_pre_push || w_pre_free || w_head_free)
                r_busy[w_sidx] <= 1'b0;
            if (w_fill) begin
                r_busy[w_sidx] <= 1'b1;
                r_slot[w_sidx] <= w_cell_q[0];
            end

            // count down busy slots after the results are out
            if (r_state == S_DEC) begin
                r_time <= r_time + 32'd1;
                for (int i = 0; i < MAX_PROCESSORS; i++) begin
                    if (r_busy[i]) begin
                        if (r_slot[i].rem != 16'd0)
                            r_slot[i].rem <= r_slot[i].rem - 16'd1;
                        if (w_preempt && r_slot[i].qrem != 16'd0)
                            r_slot[i].qrem <= r_slot[i].qrem - 16'd1;
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_load) begin
            r_out_time <= r_time;
            r_out_proc <= 3'(r_step);
            r_out_task <= w_sbusy ? {1'b0, w_stask.id} : IDLE_TASK;
            r_out_ovf  <= r_ovf;
            r_out_last <= w_last_step;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_tick_time       = r_out_time;
    assign o_processor_index = r_out_proc;
    assign o_assigned_task   = r_out_task;
    assign o_queue_overflow  = r_out_ovf;
    assign o_last_result     = r_out_last;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} <= (CW+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_dec_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DEC |=> r_state == S_IDLE)
        else $error("count-down not followed by idle");

    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_mode == MODE_TICK) |=> r_state == S_PREEMPT)
        else $error("tick transaction did not start the sequence");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> w_held <= (SW+1)'(QUEUE_DEPTH))
        else $error("more tasks held than queue depth");

endmodule

// ===== rtl/core/mts_queue_cell.sv =====
module mts_queue_cell
    import mts_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  logic [CW-1:0] i_count,
    input  t_task         i_din,
    input  t_task         i_left,
    input  t_task         i_right,
    output t_task         o_task
);

    t_task r_task;
    t_task n_task;
    logic  w_is_left;
    logic  w_left_valid;
    logic  w_right_valid;

    // pair membership for the odd-even exchange
    assign w_is_left     = (IDX % 2 == 1) ? i_ctl.phase : ~i_ctl.phase;
    assign w_right_valid = ({1'b0, i_count} > (CW+1)'(IDX + 1));
    assign w_left_valid  = (IDX > 0) && ({1'b0, i_count} > (CW+1)'(IDX));

    // next entry value
    always_comb begin
        n_task = r_task;
        case (i_ctl.op)
            CELL_LOAD: begin
                if (i_count == CW'(IDX))
                    n_task = i_din;
            end
            CELL_SHIFT_R: n_task = (IDX == 0) ? i_din : i_left;
            CELL_SHIFT_L: n_task = i_right;
            CELL_SORT: begin
                if (w_is_left) begin
                    if (w_right_valid && key_less(i_ctl.strategy, i_right, r_task))
                        n_task = i_right;
                end else begin
                    if (w_left_valid && key_less(i_ctl.strategy, r_task, i_left))
                        n_task = i_left;
                end
            end
            default: n_task = r_task;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_task <= n_task;
    end

    assign o_task = r_task;

endmodule

// ===== sim/tb_multiprocessor_task_scheduler_unit.sv =====
`timescale 1ns / 100ps

module tb_multiprocessor_task_scheduler_unit;
    import mts_pkg::*;

    localparam int NPROC       = MAX_PROCESSORS_DEF;
    localparam int QDEPTH      = QUEUE_DEPTH_DEF;
    localparam int TICK_CYCLES = 3 * NPROC + QDEPTH + NPROC + 1;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [31:0]        tick_time;
        logic [2:0]         processor_index;
        logic signed [15:0] assigned_task;
        logic               queue_overflow;
        logic               last_result;
    } t_assignment;

    typedef struct {
        logic  busy;
        t_task tsk;
    } t_slot;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_mode;
    logic [14:0]        i_task_id;
    logic [7:0]         i_task_priority;
    logic [15:0]        i_run_time;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [31:0]        o_tick_time;
    logic [2:0]         o_processor_index;
    logic signed [15:0] o_assigned_task;
    logic               o_queue_overflow;
    logic               o_last_result;

    // scheduler shadow state
    t_task       sh_queue[$];
    t_slot       sh_slots[NPROC];
    logic [31:0] sh_time;
    logic        sh_overflow;
    logic [2:0]  cfg_strategy;
    logic [3:0]  cfg_procs;
    logic [15:0] cfg_quantum;

    t_assignment expected_assignments[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          recv_hold;
    int          recv_hold_cycles;
    int          quiet_cycles;

    multiprocessor_task_scheduler_unit dut (.*);

    always #6 i_clk = ~i_clk;

    function automatic bit preempts();
        return cfg_strategy >= STRAT_SRTF && cfg_strategy <= STRAT_PRIO_SRTF;
    endfunction

    function automatic bit sorts_before(t_task a, t_task b);
        case (cfg_strategy)
            STRAT_SJF, STRAT_SRTF:     return a.rem < b.rem;
            STRAT_PRIO, STRAT_PRIO_NP: return a.prio < b.prio;
            STRAT_PRIO_SRTF:
                return (a.prio != b.prio) ? (a.prio < b.prio) : (a.rem < b.rem);
            default:                   return 1'b0;
        endcase
    endfunction

    function automatic int tasks_held();
        int n;
        n = sh_queue.size();
        foreach (sh_slots[i]) if (sh_slots[i].busy) n++;
        return n;
    endfunction

    // advance the shadow scheduler by one transaction
    function automatic void schedule_step(logic mode, logic [14:0] id, logic [7:0] prio,
                                          logic [15:0] rt);
        t_task t;
        t_task cur;
        int p;
        int j;
        t_assignment a;
        if (mode == MODE_ARRIVAL) begin
            if (tasks_held() >= QDEPTH) begin
                sh_overflow = 1'b1;
            end else begin
                t.id = id; t.prio = prio; t.rem = rt; t.qrem = cfg_quantum;
                sh_queue = {sh_queue, t};
            end
            return;
        end
        p = (cfg_procs < 1) ? 1 : (cfg_procs > NPROC) ? NPROC : cfg_procs;
        // quantum expiry and completion
        if (preempts()) begin
            for (int i = 0; i < NPROC; i++) begin
                if (!sh_slots[i].busy) continue;
                if (sh_slots[i].tsk.rem > 0 && sh_slots[i].tsk.qrem == 0) begin
                    sh_slots[i].tsk.qrem = cfg_quantum;
                    sh_queue = {sh_queue, sh_slots[i].tsk};
                    sh_slots[i].busy = 1'b0;
                end else if (sh_slots[i].tsk.rem == 0) begin
                    sh_slots[i].busy = 1'b0;
                end
            end
        end
        // stable insertion sort
        for (int i = 1; i < sh_queue.size(); i++) begin
            cur = sh_queue[i];
            j = i;
            while (j > 0 && sorts_before(cur, sh_queue[j-1])) begin
                sh_queue[j] = sh_queue[j-1];
                j--;
            end
            sh_queue[j] = cur;
        end
        // running tasks back to the head
        for (int i = NPROC - 1; i >= 0; i--) begin
            if (!sh_slots[i].busy) continue;
            if (sh_slots[i].tsk.rem > 0) sh_queue.push_front(sh_slots[i].tsk);
            sh_slots[i].busy = 1'b0;
        end
        // fill from the head
        for (int i = 0; i < p && sh_queue.size() > 0; i++) begin
            sh_slots[i].tsk  = sh_queue.pop_front();
            sh_slots[i].busy = 1'b1;
        end
        // report, then count down
        for (int i = 0; i < p; i++) begin
            a.tick_time       = sh_time;
            a.processor_index = i[2:0];
            a.assigned_task   = sh_slots[i].busy ? {1'b0, sh_slots[i].tsk.id} : IDLE_TASK;
            a.queue_overflow  = sh_overflow;
            a.last_result     = (i == p - 1);
            expected_assignments = {expected_assignments, a};
        end
        for (int i = 0; i < p; i++) begin
            if (!sh_slots[i].busy) continue;
            if (sh_slots[i].tsk.rem > 0) sh_slots[i].tsk.rem--;
            if (preempts() && sh_slots[i].tsk.qrem > 0) sh_slots[i].tsk.qrem--;
        end
        sh_time++;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // one transaction on the input channel
    task automatic send_item(logic mode, logic [14:0] id, logic [7:0] prio, logic [15:0] rt);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_mode          <= mode;
        i_task_id       <= id;
        i_task_priority <= prio;
        i_run_time      <= rt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        schedule_step(mode, id, prio, rt);
    endtask

    task automatic send_arrival(logic [14:0] id, logic [7:0] prio, logic [15:0] rt);
        send_item(MODE_ARRIVAL, id, prio, rt);
    endtask

    task automatic send_tick();
        send_item(MODE_TICK, 15'($urandom), 8'($urandom), 16'($urandom));
    endtask

    // wait until every result is in and the block has settled
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_assignments.size() != 0) @(posedge i_clk);
        repeat (TICK_CYCLES + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_STRATEGY: cfg_strategy = val[2:0];
            CFG_PROCS:    cfg_procs    = val[3:0];
            CFG_QUANTUM:  cfg_quantum  = val;
            default: ;
        endcase
    endtask

    task automatic configure(logic [2:0] strat, logic [3:0] procs, logic [15:0] quant);
        drain();
        write_reg(CFG_STRATEGY, {13'd0, strat});
        write_reg(CFG_PROCS, {12'd0, procs});
        write_reg(CFG_QUANTUM, quant);
        i_cfg_wr_en <= 1'b0;
    endtask

    // field extremes, overflow, zero run time and zero quantum
    task automatic test_directed();
        send_tick();
        send_arrival(15'h7FFF, 8'hFF, 16'hFFFF);
        send_arrival(15'h0000, 8'h00, 16'h0000);
        send_arrival(15'h2AAA, 8'h55, 16'h0001);
        send_tick();
        send_tick();
        configure(STRAT_PRIO_SRTF, 4'd0, 16'd0);
        for (int i = 0; i < 17; i++)
            send_arrival(i[14:0] ^ 15'h5555, i[7:0] & 8'h3, i[15:0] + 16'd1);
        send_tick();
        configure(STRAT_RR, 4'd15, 16'hFFFF);
        send_tick();
        send_tick();
    endtask

    // mostly arrivals with short run times under one setting
    task automatic test_random(logic [2:0] strat, logic [3:0] procs, logic [15:0] quant,
                               int count);
        logic [15:0] rt;
        logic [7:0]  pr;
        configure(strat, procs, quant);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 45) begin
                send_tick();
            end else begin
                rt = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
                pr = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
                send_arrival(15'($urandom), pr, rt);
            end
        end
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        configure(STRAT_SJF, 4'd8, 16'd2);
        recv_hold_cycles = 400;
        recv_hold = 1'b1;
        for (int i = 0; i < 12; i++) begin
            send_arrival(15'($urandom), 8'($urandom), 16'($urandom_range(1, 9)));
            send_tick();
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (!recv_hold);
        drain();
    endtask

    // receiver with random stalls and hold-off
    always @(posedge i_clk) begin
        if (recv_hold) begin
            i_out_ready <= 1'b0;
            recv_hold_cycles <= recv_hold_cycles - 1;
            if (recv_hold_cycles <= 1) recv_hold <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checking
    always @(posedge i_clk) begin
        t_assignment w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_assignments.size() == 0) begin
                report_mismatch("unexpected result transaction", 32'd0, 32'd0);
            end else begin
                w = expected_assignments.pop_front();
                if (o_tick_time !== w.tick_time)
                    report_mismatch("tick_time", o_tick_time, w.tick_time);
                if (o_processor_index !== w.processor_index)
                    report_mismatch("processor_index", 32'(o_processor_index),
                                    32'(w.processor_index));
                if (o_assigned_task !== w.assigned_task)
                    report_mismatch("assigned_task", 32'(o_assigned_task), 32'(w.assigned_task));
                if (o_queue_overflow !== w.queue_overflow)
                    report_mismatch("queue_overflow", 32'(o_queue_overflow),
                                    32'(w.queue_overflow));
                if (o_last_result !== w.last_result)
                    report_mismatch("last_result", 32'(o_last_result), 32'(w.last_result));
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("tb_multiprocessor_task_scheduler_unit NOT OK");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0; i_rst_n = 1'b0; i_cfg_wr_en = 1'b0; i_cfg_index = '0;
        i_cfg_wdata = '0; i_in_valid = 1'b0; i_mode = MODE_ARRIVAL; i_task_id = '0;
        i_task_priority = '0; i_run_time = '0; i_out_ready = 1'b0;
        mismatches = 0; quiet_cycles = 0; recv_hold = 1'b0; recv_hold_cycles = 0;
        send_idle_pct = 12; recv_idle_pct = 58;
        sh_time = '0; sh_overflow = 1'b0; cfg_strategy = STRAT_FCFS; cfg_procs = 4'd1;
        cfg_quantum = 16'd1;
        foreach (sh_slots[i]) sh_slots[i].busy = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(STRAT_FCFS, 4'd2, 16'd1, 25);
        test_random(STRAT_SJF, 4'd3, 16'd3, 25);
        send_idle_pct = 58; recv_idle_pct = 12;
        test_random(STRAT_SRTF, 4'd4, 16'd2, 25);
        test_random(STRAT_RR, 4'd1, 16'd1, 25);
        test_backpressure();
        test_random(STRAT_PRIO, 4'd8, 16'd2, 25);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(STRAT_PRIO_SRTF, 4'd5, 16'd1, 25);
        test_random(STRAT_PRIO_NP, 4'd3, 16'd4, 25);
        test_random(3'd7, 4'd9, 16'd2, 20);
        test_random(STRAT_SRTF, 4'd6, 16'hFFFF, 20);
        drain();
        if (mismatches == 0 && expected_assignments.size() == 0)
            $display("tb_multiprocessor_task_scheduler_unit OK");
        else
            $display("tb_multiprocessor_task_scheduler_unit NOT OK");
        $finish;
    end

endmodule
